FILE: rtl/cda_pkg.sv
// Package with the calendar tables and pipeline transfer types of the date shifter.
`default_nettype none
package cda_pkg;

    localparam int CYCLE_DAYS = 1461;

    typedef struct packed {
        logic              valid;
        logic signed [13:0] pos;
        logic [5:0]        cyc;
    } enc_t;

    typedef struct packed {
        logic        valid;
        logic [10:0] pos;
        logic signed [7:0] cyc;
    } cyc_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] year;
        logic [3:0] month;
        logic [4:0] day;
        logic       wrapped;
    } res_t;

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        case (m) inside
            4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
            4'd2:                    len = leap ? 5'd29 : 5'd28;
            default:                 len = 5'd31;
        endcase
        return len;
    endfunction

    function automatic logic [8:0] days_before(input logic [3:0] m, input logic leap);
        logic [8:0] d;
        case (m)
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            default: d = 9'd0;
        endcase
        if (leap && (m > 4'd2))
        begin
            d = d + 9'd1;
        end
        return d;
    endfunction

    function automatic logic [10:0] year_off(input logic [1:0] k);
        logic [10:0] o;
        case (k)
            2'd1:    o = 11'd366;
            2'd2:    o = 11'd731;
            2'd3:    o = 11'd1096;
            default: o = 11'd0;
        endcase
        return o;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/cda_encode.sv
// Date normalisation, day position within the four-year cycle and offset addition.
`default_nettype none
module cda_encode (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic [7:0]         year_in,
    input  logic [3:0]         month_in,
    input  logic [4:0]         day_in,
    input  logic signed [12:0] delta_days,
    output cda_pkg::enc_t      enc
);
    import cda_pkg::*;

    logic              s1_valid_reg;
    logic [10:0]       s1_pos_reg;
    logic [5:0]        s1_cyc_reg;
    logic signed [12:0] s1_delta_reg;
    logic              s2_valid_reg;
    logic signed [13:0] s2_pos_reg;
    logic [5:0]        s2_cyc_reg;

    logic [3:0]  m_norm;
    logic        leap;
    logic [4:0]  len;
    logic [4:0]  d_norm;
    logic [10:0] s1_pos_next;
    logic signed [13:0] s2_pos_next;

    always_comb
    begin
        if (month_in == 4'd0)
        begin
            m_norm = 4'd1;
        end
        else if (month_in > 4'd12)
        begin
            m_norm = 4'd12;
        end
        else
        begin
            m_norm = month_in;
        end
        leap = (year_in[1:0] == 2'd0);
        len  = month_len(m_norm, leap);
        if (day_in == 5'd0)
        begin
            d_norm = 5'd1;
        end
        else if (day_in > len)
        begin
            d_norm = len;
        end
        else
        begin
            d_norm = day_in;
        end
        s1_pos_next = year_off(year_in[1:0]) + {2'b00, days_before(m_norm, leap)}
                      + {6'd0, d_norm} - 11'd1;
        s2_pos_next = signed'({3'b000, s1_pos_reg}) + 14'(s1_delta_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_pos_reg   <= s1_pos_next;
        s1_cyc_reg   <= year_in[7:2];
        s1_delta_reg <= delta_days;
        s2_pos_reg   <= s2_pos_next;
        s2_cyc_reg   <= s1_cyc_reg;
    end

    assign enc.valid = s2_valid_reg;
    assign enc.pos   = s2_pos_reg;
    assign enc.cyc   = s2_cyc_reg;

endmodule
`default_nettype wire

FILE: rtl/cda_wrap.sv
// Reduction of the shifted day position into a four-year cycle index and offset.
`default_nettype none
module cda_wrap (
    input  logic          clk,
    input  logic          rst_n,
    input  cda_pkg::enc_t enc,
    output cda_pkg::cyc_t cyc
);
    import cda_pkg::*;

    localparam logic signed [13:0] Cyc1 = 14'(CYCLE_DAYS);
    localparam logic signed [13:0] Cyc2 = 14'(2 * CYCLE_DAYS);
    localparam logic signed [13:0] Cyc3 = 14'(3 * CYCLE_DAYS);

    logic              valid_reg;
    logic [10:0]       pos_reg;
    logic signed [7:0] cyc_reg;

    logic signed [7:0]  q;
    logic signed [13:0] corr;
    logic signed [13:0] pos_full;
    logic [10:0]        pos_next;
    logic signed [7:0]  cyc_next;

    always_comb
    begin
        if (enc.pos >= Cyc3)
        begin
            q = 8'sd3;
        end
        else if (enc.pos >= Cyc2)
        begin
            q = 8'sd2;
        end
        else if (enc.pos >= Cyc1)
        begin
            q = 8'sd1;
        end
        else if (enc.pos >= 14'sd0)
        begin
            q = 8'sd0;
        end
        else if (enc.pos >= -Cyc1)
        begin
            q = -8'sd1;
        end
        else if (enc.pos >= -Cyc2)
        begin
            q = -8'sd2;
        end
        else
        begin
            q = -8'sd3;
        end
        case (q)
            8'sd3:   corr = Cyc3;
            8'sd2:   corr = Cyc2;
            8'sd1:   corr = Cyc1;
            -8'sd1:  corr = -Cyc1;
            -8'sd2:  corr = -Cyc2;
            -8'sd3:  corr = -Cyc3;
            default: corr = 14'sd0;
        endcase
        pos_full = enc.pos - corr;
        pos_next = pos_full[10:0];
        cyc_next = signed'({2'b00, enc.cyc}) + q;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= enc.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg <= pos_next;
        cyc_reg <= cyc_next;
    end

    assign cyc.valid = valid_reg;
    assign cyc.pos   = pos_reg;
    assign cyc.cyc   = cyc_reg;

endmodule
`default_nettype wire

FILE: rtl/cda_decode.sv
// Conversion of a cycle index and day position back into year, month and day.
`default_nettype none
module cda_decode (
    input  logic          clk,
    input  logic          rst_n,
    input  cda_pkg::cyc_t cyc,
    output cda_pkg::res_t res
);
    import cda_pkg::*;

    logic              s4_valid_reg;
    logic [8:0]        s4_doy_reg;
    logic              s4_leap_reg;
    logic [7:0]        s4_year_reg;
    logic              s4_wrapped_reg;
    logic              s5_valid_reg;
    logic [7:0]        s5_year_reg;
    logic [3:0]        s5_month_reg;
    logic [4:0]        s5_day_reg;
    logic              s5_wrapped_reg;

    logic [1:0]        k;
    logic [10:0]       doy_full;
    logic signed [9:0] yfull;
    logic [3:0]        month_next;
    logic [8:0]        day_full;

    always_comb
    begin
        if (cyc.pos >= 11'd1096)
        begin
            k = 2'd3;
        end
        else if (cyc.pos >= 11'd731)
        begin
            k = 2'd2;
        end
        else if (cyc.pos >= 11'd366)
        begin
            k = 2'd1;
        end
        else
        begin
            k = 2'd0;
        end
        doy_full = cyc.pos - year_off(k);
        yfull    = {cyc.cyc, k};

        month_next = 4'd1;
        for (int i = 2; i <= 12; i++)
        begin
            if (s4_doy_reg >= days_before(4'(i), s4_leap_reg))
            begin
                month_next = 4'(i);
            end
        end
        day_full = s4_doy_reg - days_before(month_next, s4_leap_reg) + 9'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else
        begin
            s4_valid_reg <= cyc.valid;
            s5_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s4_doy_reg     <= doy_full[8:0];
        s4_leap_reg    <= (k == 2'd0);
        s4_year_reg    <= yfull[7:0];
        s4_wrapped_reg <= (yfull[9:8] != 2'b00);
        s5_year_reg    <= s4_year_reg;
        s5_month_reg   <= month_next;
        s5_day_reg     <= day_full[4:0];
        s5_wrapped_reg <= s4_wrapped_reg;
    end

    assign res.valid   = s5_valid_reg;
    assign res.year    = s5_year_reg;
    assign res.month   = s5_month_reg;
    assign res.day     = s5_day_reg;
    assign res.wrapped = s5_wrapped_reg;

endmodule
`default_nettype wire

FILE: rtl/calendar_date_add_days_top.sv
// Top level of the calendar date shifter.
// The block accepts a transfer on every clock cycle at which start is high; busy is held
// low because the five-stage pipeline has no loop and never has to hold off a new date.
// Each result is on the outputs for one cycle, marked by done, after passing the five
// register stages: normalisation, offset addition, cycle reduction, year split and month
// lookup. The receiver cannot stall, so it must take every result in that cycle. Results
// leave in the order the dates arrived. Dates outside the calendar are first pulled to
// the nearest valid date.
`default_nettype none
module calendar_date_add_days_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [7:0]         year_in,
    input  logic [3:0]         month_in,
    input  logic [4:0]         day_in,
    input  logic signed [12:0] delta_days,
    output logic               done,
    output logic [7:0]         year_out,
    output logic [3:0]         month_out,
    output logic [4:0]         day_out,
    output logic               year_wrapped
);
    import cda_pkg::*;

    enc_t enc;
    cyc_t cyc;
    res_t res;

    assign busy = 1'b0;

    cda_encode u_encode (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (start & ~busy),
        .year_in    (year_in),
        .month_in   (month_in),
        .day_in     (day_in),
        .delta_days (delta_days),
        .enc        (enc)
    );

    cda_wrap u_wrap (
        .clk   (clk),
        .rst_n (rst_n),
        .enc   (enc),
        .cyc   (cyc)
    );

    cda_decode u_decode (
        .clk   (clk),
        .rst_n (rst_n),
        .cyc   (cyc),
        .res   (res)
    );

    assign done         = res.valid;
    assign year_out     = res.year;
    assign month_out    = res.month;
    assign day_out      = res.day;
    assign year_wrapped = res.wrapped;

`ifndef SYNTH
    a_done_follows_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, 5))
        else $error("done without a transfer five cycles earlier");

    a_start_gives_done: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##5 done)
        else $error("transfer produced no result");

    a_date_valid: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (month_out >= 4'd1) && (month_out <= 4'd12) && (day_out >= 5'd1)
                 && (day_out <= 5'd31))
        else $error("result is not a calendar date");

    a_wrap_near_edge: assert property (@(posedge clk) disable iff (!rst_n)
        (done && year_wrapped) |-> (year_out >= 8'd244) || (year_out <= 8'd11))
        else $error("year wrap flagged far from the range edge");
`endif

endmodule
`default_nettype wire
